// ===== src/sitar_pkg.sv =====
// Shared types, constants and the digit-to-character function for the radix text converter.
package sitar_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned BaseWidth    = 8;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned RadixWidth   = 5;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned ChunkWidth   = 8;
  localparam int unsigned MaxDigits    = 32;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [BaseWidth-1:0] BaseMin = 8'd2;
  localparam logic [BaseWidth-1:0] BaseMax = 8'd16;

  localparam logic [CharWidth-1:0] CharMinus = 8'h2d;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharA     = 8'h61;
  localparam logic [CharWidth-1:0] CharNone  = 8'h00;

  typedef struct packed {
    logic [ValueWidth-1:0] mag;
    logic [RadixWidth-1:0] radix;
    logic                  neg;
    logic                  err;
  } sitar_item_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = CharA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== src/sitar_front.sv =====
// Front end: checks the base and takes the magnitude of the incoming value.
module sitar_front
  import sitar_pkg::*;
(
  input  logic [ValueWidth-1:0] value_i,
  input  logic [BaseWidth-1:0]  base_i,
  output sitar_item_t           item_o
);

  logic neg;

  assign neg = value_i[ValueWidth-1];

  always_comb begin
    item_o.neg   = neg;
    item_o.mag   = neg ? ('0 - value_i) : value_i;
    item_o.radix = base_i[RadixWidth-1:0];
    item_o.err   = (base_i < BaseMin) || (base_i > BaseMax);
  end

endmodule

// ===== src/sitar_queue.sv =====
// Short queue of classified items between the front end and the digit engine.
module sitar_queue
  import sitar_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sitar_item_t item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output sitar_item_t item_o
);

  localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [AddrWidth-1:0]  LastAddr = AddrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  sitar_item_t mem_q [Depth];
  logic [AddrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountWidth-1:0] count_q;

  assign full_o  = (count_q == FullCount);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/sitar_back.sv =====
// Digit engine: divides by the base eight bits a cycle, stacks digits, emits characters.
module sitar_back
  import sitar_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sitar_item_t          item_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [CharWidth-1:0] char_o,
  output logic                 last_o,
  output logic                 err_o
);

  localparam int unsigned Chunks     = ValueWidth / ChunkWidth;
  localparam int unsigned StepWidth  = $clog2(Chunks);
  localparam int unsigned CountWidth = $clog2(MaxDigits + 1);
  localparam int unsigned IdxWidth   = $clog2(MaxDigits);
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(Chunks - 1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e                  state_q;
  logic [ValueWidth-1:0]   div_q, div_d;
  logic [DigitWidth-1:0]   rem_q, rem_d;
  logic [StepWidth-1:0]    step_q;
  logic [RadixWidth-1:0]   radix_q;
  logic                    sign_q;
  logic [CountWidth-1:0]   cnt_q;
  logic [DigitWidth-1:0]   stack_q [MaxDigits];
  logic                    out_valid_q;
  logic [CharWidth-1:0]    out_char_q;
  logic                    out_last_q;
  logic                    out_err_q;
  logic                    load_ok;
  logic                    push;
  logic [ChunkWidth-1:0]   qbits;
  logic [IdxWidth-1:0]     top_idx;

  assign load_ok = !out_valid_q || ready_i;
  assign pop_o   = (state_q == StIdle) && valid_i && (!item_i.err || load_ok);
  assign push    = (state_q == StDiv) && (step_q == LastStep);
  assign top_idx = IdxWidth'(cnt_q - 1'b1);

  always_comb begin
    logic [DigitWidth:0] t;
    logic [DigitWidth-1:0] r;
    r = rem_q;
    qbits = '0;
    for (int i = ChunkWidth - 1; i >= 0; i--) begin
      t = {r, div_q[ValueWidth-ChunkWidth+i]};
      if (t >= radix_q) begin
        qbits[i] = 1'b1;
        t = t - radix_q;
      end
      r = t[DigitWidth-1:0];
    end
    rem_d = r;
    div_d = {div_q[ValueWidth-ChunkWidth-1:0], qbits};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[cnt_q[IdxWidth-1:0]] <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      radix_q     <= '0;
      sign_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      if (out_valid_q && ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            if (item_i.err) begin
              out_valid_q <= 1'b1;
              out_char_q  <= CharNone;
              out_last_q  <= 1'b1;
              out_err_q   <= 1'b1;
            end else begin
              div_q   <= item_i.mag;
              radix_q <= item_i.radix;
              sign_q  <= item_i.neg;
              rem_q   <= '0;
              step_q  <= '0;
              cnt_q   <= '0;
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          div_q  <= div_d;
          rem_q  <= rem_d;
          step_q <= step_q + 1'b1;
          if (push) begin
            rem_q <= '0;
            cnt_q <= cnt_q + 1'b1;
            if (div_d == '0) begin
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          if (load_ok) begin
            out_valid_q <= 1'b1;
            out_err_q   <= 1'b0;
            if (sign_q) begin
              sign_q     <= 1'b0;
              out_char_q <= CharMinus;
              out_last_q <= 1'b0;
            end else begin
              out_char_q <= digit_char(stack_q[top_idx]);
              out_last_q <= (cnt_q == CountWidth'(1));
              cnt_q      <= cnt_q - 1'b1;
              if (cnt_q == CountWidth'(1)) begin
                state_q <= StIdle;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign valid_o = out_valid_q;
  assign char_o  = out_char_q;
  assign last_o  = out_last_q;
  assign err_o   = out_err_q;

endmodule

// ===== src/signed_int_to_ascii_radix_top.sv =====
// Top level of the signed integer to ASCII converter for bases 2 to 16.
//
// Each input beat carries a 32-bit signed value and a base; the block returns the
// value's text, most significant character first, one character per output beat,
// with tlast on the final character. A base outside 2 to 16 returns a single beat
// with tuser set and a zero character. The digit engine divides the magnitude by
// the base eight dividend bits per cycle, and the characters then leave at one
// per cycle while the output is not stalled.
// A small input queue takes further numbers while the engine is busy.
module signed_int_to_ascii_radix_top
  import sitar_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value [31:0], base [39:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // char_out [7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // error [0]
);

  sitar_item_t front_item;
  sitar_item_t queue_item;
  logic        queue_full;
  logic        queue_valid;
  logic        queue_pop;
  logic        push;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  sitar_front u_front (
    .value_i (s_axis_tdata[ValueWidth-1:0]),
    .base_i  (s_axis_tdata[ValueWidth+BaseWidth-1:ValueWidth]),
    .item_o  (front_item)
  );

  sitar_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  sitar_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .item_i  (queue_item),
    .pop_o   (queue_pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .char_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .err_o   (m_axis_tuser)
  );

endmodule

// ===== src/sitar_chk.sv =====
// Port-level checks for the converter, bound to the top level.
module sitar_chk
  import sitar_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == CharNone))
    else $error("error beat without tlast or with nonzero character");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata == CharMinus) ||
      ((m_axis_tdata >= CharZero) && (m_axis_tdata <= CharZero + 8'd9)) ||
      ((m_axis_tdata >= CharA) && (m_axis_tdata <= CharA + 8'd5)))
    else $error("character outside the digit set");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && (m_axis_tdata == CharMinus) |-> !m_axis_tlast)
    else $error("sign beat marked last");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

endmodule

bind signed_int_to_ascii_radix_top sitar_chk u_sitar_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
